// ----- rtl/free_extent_block_allocator_defines.svh -----
// Assertion macros used by the port-level checker of the free extent block allocator.
`ifndef FREE_EXTENT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FREE_EXTENT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FEBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FEBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/feba_pkg.sv -----
// Package with the types and constants of the free extent block allocator.
`timescale 1ns / 1ps

package feba_pkg;

    localparam int BLOCK_COUNT_DEFAULT = 4096;
    localparam int MAX_BLOCKS          = 4096;

    localparam int BLOCK_W  = 12;
    localparam int RUN_W    = 12;
    localparam int REC_W    = RUN_W + BLOCK_W;
    localparam int VOL_W    = 13;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [VOL_W-1:0]   VOLUME_RESET = 13'd4096;
    localparam logic [BLOCK_W-1:0] FREE_MAX     = 12'hFFF;
    localparam logic [RUN_W-1:0]   RUN_ONE      = 12'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_FORMAT  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_FREE   = 2'd1,
        STATUS_BAD_BLOCK = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

// ----- rtl/feba_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module feba_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/free_extent_block_allocator.sv -----
// Top level of the free extent block allocator.
//
// The input channel carries one word per operation: action (0 allocate, 1 release,
// 2 format) and block_number. A word is taken when in_valid is high and in_stall low.
// Each word yields exactly one result word on the output channel with given_block,
// status and free_left, taken when out_valid is high and out_stall low.
// An allocate with free blocks reads the head extent record from the record RAM and,
// in the ST_READ state, writes the successor record back when that extent holds more
// than one block. Release, format, an allocate on an empty list and an unknown action
// finish in the idle state, and their result reaches the output register in the cycle
// after acceptance; an allocate with free blocks loads its result from ST_READ.
// A new word is taken while the previous result is being handed over.
// When the receiver stalls, the result register holds its word and in_stall stays high.
// Reset empties the free list (head and count zero) and sets vol_reg to 4096.
// The record RAM is not cleared; format the volume before allocating. The user must
// write vol_reg via cfg_wr_en/cfg_wr_data while idle; the block does not enforce it.
`timescale 1ns / 1ps

module free_extent_block_allocator #(
    parameter int BLOCK_COUNT = feba_pkg::BLOCK_COUNT_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [feba_pkg::VOL_W-1:0]     cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [feba_pkg::ACTION_W-1:0]  action,
    input  logic [feba_pkg::BLOCK_W-1:0]   block_number,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [feba_pkg::BLOCK_W-1:0]   given_block,
    output logic [feba_pkg::STATUS_W-1:0]  status,
    output logic [feba_pkg::BLOCK_W-1:0]   free_left
);

    import feba_pkg::*;

    localparam int MEM_DEPTH = (BLOCK_COUNT < MAX_BLOCKS) ? BLOCK_COUNT : MAX_BLOCKS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [VOL_W-1:0] STORE_LIMIT = VOL_W'(MEM_DEPTH);

    state_t               state_reg, state_next;
    logic [BLOCK_W-1:0]   head_reg, head_next;
    logic [BLOCK_W-1:0]   free_reg, free_next;
    logic [VOL_W-1:0]     vol_reg;
    logic                 hit_reg, hit_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0]   given_reg, given_next;
    status_t              status_reg, status_next;
    logic [BLOCK_W-1:0]   free_out_reg, free_out_next;

    logic                 accept;
    logic [VOL_W-1:0]     eff_vol;
    logic [VOL_W-1:0]     eff_vol_m1;
    logic [REC_W-1:0]     rec;
    logic [RUN_W-1:0]     run;
    logic [BLOCK_W-1:0]   next_blk;
    logic [BLOCK_W-1:0]   head_inc;

    logic                 mem_we;
    logic [BLOCK_W-1:0]   mem_waddr;
    logic [REC_W-1:0]     mem_wdata;
    logic                 mem_re;
    logic [REC_W-1:0]     mem_rdata;

    assign eff_vol    = (vol_reg < STORE_LIMIT) ? vol_reg : STORE_LIMIT;
    assign eff_vol_m1 = eff_vol - VOL_W'(1);
    assign in_stall   = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept     = in_valid && !in_stall;
    assign rec        = hit_reg ? mem_rdata : '0;
    assign run        = rec[REC_W-1:BLOCK_W];
    assign next_blk   = rec[BLOCK_W-1:0];
    assign head_inc   = head_reg + BLOCK_W'(1);

    feba_ram #(
        .WIDTH (REC_W),
        .DEPTH (MEM_DEPTH)
    ) u_records (
        .clk     (clk),
        .wr_en   (mem_we && (VOL_W'(mem_waddr) < STORE_LIMIT)),
        .wr_addr (mem_waddr[AW-1:0]),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (head_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            free_reg      <= '0;
            vol_reg       <= VOLUME_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                vol_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg      <= hit_next;
        given_reg    <= given_next;
        status_reg   <= status_next;
        free_out_reg <= free_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        free_next      = free_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && out_stall;
        given_next     = given_reg;
        status_next    = status_reg;
        free_out_next  = free_out_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    given_next  = '0;
                    status_next = STATUS_OK;
                    case (action_t'(action))
                        ACT_ALLOC:
                        begin
                            if (free_reg == '0)
                            begin
                                status_next    = STATUS_NO_FREE;
                                free_out_next  = free_reg;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                hit_next   = VOL_W'(head_reg) < STORE_LIMIT;
                                state_next = ST_READ;
                            end
                        end
                        ACT_RELEASE:
                        begin
                            if ((block_number == '0) || (VOL_W'(block_number) >= eff_vol))
                            begin
                                status_next = STATUS_BAD_BLOCK;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = block_number;
                                mem_wdata = {RUN_ONE, head_reg};
                                head_next = block_number;
                                if (free_reg != FREE_MAX)
                                begin
                                    free_next = free_reg + BLOCK_W'(1);
                                end
                            end
                            free_out_next  = free_next;
                            out_valid_next = 1'b1;
                        end
                        ACT_FORMAT:
                        begin
                            if (eff_vol < VOL_W'(2))
                            begin
                                free_next = '0;
                                head_next = '0;
                            end
                            else
                            begin
                                free_next = eff_vol_m1[BLOCK_W-1:0];
                                head_next = BLOCK_W'(1);
                                mem_we    = 1'b1;
                                mem_waddr = BLOCK_W'(1);
                                mem_wdata = {eff_vol_m1[RUN_W-1:0], {BLOCK_W{1'b0}}};
                            end
                            free_out_next  = free_next;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            free_out_next  = free_reg;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                free_next = free_reg - BLOCK_W'(1);
                if (run <= RUN_ONE)
                begin
                    head_next = next_blk;
                end
                else
                begin
                    head_next = head_inc;
                    mem_we    = 1'b1;
                    mem_waddr = head_inc;
                    mem_wdata = {run - RUN_ONE, next_blk};
                end
                given_next     = head_reg;
                status_next    = STATUS_OK;
                free_out_next  = free_next;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign given_block = given_reg;
    assign status      = status_reg;
    assign free_left   = free_out_reg;

endmodule

// ----- rtl/feba_checker.sv -----
// Port-level checker for the free extent block allocator and its bind statement.
`timescale 1ns / 1ps
`include "free_extent_block_allocator_defines.svh"

module feba_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic [feba_pkg::ACTION_W-1:0]  action,
    input logic [feba_pkg::BLOCK_W-1:0]   block_number,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [feba_pkg::BLOCK_W-1:0]   given_block,
    input logic [feba_pkg::STATUS_W-1:0]  status,
    input logic [feba_pkg::BLOCK_W-1:0]   free_left
);

    import feba_pkg::*;

    `FEBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(given_block) && $stable(status) && $stable(free_left), "Stalled result word changed.")

    `FEBA_ASSERT_NOW(a_no_free, out_valid && (status == STATUS_NO_FREE), (given_block == '0) && (free_left == '0), "Empty-list result is not block 0 with no free blocks.")

    `FEBA_ASSERT_NOW(a_bad_block, out_valid && (status == STATUS_BAD_BLOCK), given_block == '0, "Rejected release handed out a block.")

    `FEBA_ASSERT_NOW(a_alloc_count, out_valid && (given_block != '0), (status == STATUS_OK) && (free_left != FREE_MAX), "Allocation result has an inconsistent status or count.")

endmodule

bind free_extent_block_allocator feba_checker u_feba_checker (.*);

// ----- verif/feba_reply_checker.sv -----
// Checker that tracks the allocator's free list and compares every reply word with its forecast.
`timescale 1ns / 1ps

module feba_reply_checker
    import feba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [VOL_W-1:0]    cfg_wr_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [BLOCK_W-1:0]  block_number,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [BLOCK_W-1:0]  given_block,
    input  logic [STATUS_W-1:0] status,
    input  logic [BLOCK_W-1:0]  free_left,
    output int                  mismatch_count,
    output int                  results_owed
);

    typedef struct packed {
        logic [BLOCK_W-1:0] given;
        status_t            stat;
        logic [BLOCK_W-1:0] left;
    } reply_t;

    logic [REC_W-1:0]   extent_rec [0:MAX_BLOCKS-1];
    logic [BLOCK_W-1:0] head = '0;
    logic [BLOCK_W-1:0] free_cnt = '0;
    logic [VOL_W-1:0]   vol_reg = VOLUME_RESET;
    reply_t             pending_replies [$];
    int                 errs = 0;

    initial mismatch_count = 0;
    initial results_owed = 0;

    function automatic logic [VOL_W-1:0] usable_blocks();
        return (vol_reg > VOL_W'(MAX_BLOCKS)) ? VOL_W'(MAX_BLOCKS) : vol_reg;
    endfunction

    // Applies one operation to the tracked free list and returns the reply it must produce.
    function automatic reply_t serve_request(input logic [ACTION_W-1:0] act,
                                             input logic [BLOCK_W-1:0] blk);
        reply_t           r;
        logic [REC_W-1:0] rec;
        logic [RUN_W-1:0] run;
        logic [VOL_W-1:0] span;
        r.given = '0;
        r.stat = STATUS_OK;
        span = usable_blocks();
        case (act)
            ACT_ALLOC:
            begin
                if (free_cnt == '0)
                begin
                    r.stat = STATUS_NO_FREE;
                end
                else
                begin
                    rec = extent_rec[head];
                    run = rec[REC_W-1:BLOCK_W];
                    r.given = head;
                    free_cnt = free_cnt - 1'b1;
                    if (run <= RUN_ONE)
                    begin
                        head = rec[BLOCK_W-1:0];
                    end
                    else
                    begin
                        head = head + 1'b1;
                        extent_rec[head] = {run - RUN_ONE, rec[BLOCK_W-1:0]};
                    end
                end
            end
            ACT_RELEASE:
            begin
                if (blk == '0 || {1'b0, blk} >= span)
                begin
                    r.stat = STATUS_BAD_BLOCK;
                end
                else
                begin
                    extent_rec[blk] = {RUN_ONE, head};
                    head = blk;
                    if (free_cnt != FREE_MAX)
                    begin
                        free_cnt = free_cnt + 1'b1;
                    end
                end
            end
            ACT_FORMAT:
            begin
                if (span < VOL_W'(2))
                begin
                    free_cnt = '0;
                    head = '0;
                end
                else
                begin
                    free_cnt = BLOCK_W'(span - 1'b1);
                    head = BLOCK_W'(1);
                    extent_rec[1] = {RUN_W'(span - 1'b1), BLOCK_W'(0)};
                end
            end
            default:
            begin
            end
        endcase
        r.left = free_cnt;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reply_t want;
        if (!rst_n)
        begin
            head = '0;
            free_cnt = '0;
            vol_reg = VOLUME_RESET;
            pending_replies.delete();
            errs = 0;
            results_owed <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                vol_reg = cfg_wr_data;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: reply word with none outstanding: given_block %0d status %0d free_left %0d",
                             $time, given_block, status, free_left);
                    errs++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (given_block !== want.given)
                    begin
                        $display("%0t: given_block expected %0d, got %0d",
                                 $time, want.given, given_block);
                        errs++;
                    end
                    if (status !== want.stat)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time, want.stat, status);
                        errs++;
                    end
                    if (free_left !== want.left)
                    begin
                        $display("%0t: free_left expected %0d, got %0d",
                                 $time, want.left, free_left);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pending_replies.push_back(serve_request(action, block_number));
            end
            results_owed <= pending_replies.size();
            mismatch_count <= errs;
        end
    end

endmodule

// ----- verif/tb.sv -----
// Top of the allocator testbench: clock, reset, request stimulus, reply stalls and verdict.
`timescale 1ns / 1ps

module tb;
    import feba_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [VOL_W-1:0]    cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action = '0;
    logic [BLOCK_W-1:0]  block_number = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [BLOCK_W-1:0]  given_block;
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  free_left;
    int                  mismatch_count;
    int                  results_owed;

    int burst_left = 0;
    int stall_style = 0;
    int stall_span = 0;
    int vol_now = MAX_BLOCKS;
    int settings_used = 1;
    int n_alloc = 0;
    int n_release = 0;
    int n_format = 0;
    int n_unused = 0;

    free_extent_block_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .given_block  (given_block),
        .status       (status),
        .free_left    (free_left)
    );

    feba_reply_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .block_number   (block_number),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .given_block    (given_block),
        .status         (status),
        .free_left      (free_left),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d reply words outstanding.", results_owed);
        $display("FAIL free_extent_block_allocator");
        $finish;
    end

    // The receiver switches between free flow, light, heavy and alternating stalls.
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_span = $urandom_range(8, 60);
        end
        else
        begin
            stall_span--;
        end
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
        endcase
    end

    task automatic push_word(input logic [ACTION_W-1:0] act, input logic [BLOCK_W-1:0] blk);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        action <= act;
        block_number <= blk;
        case (act)
            ACT_ALLOC: n_alloc++;
            ACT_RELEASE: n_release++;
            ACT_FORMAT: n_format++;
            default: n_unused++;
        endcase
        @(posedge clk);
        while (!(in_valid && !in_stall)) @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_volume(input logic [VOL_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        vol_now = (v > MAX_BLOCKS) ? MAX_BLOCKS : int'(v);
        settings_used++;
    endtask

    function automatic logic [BLOCK_W-1:0] pick_release(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1 || span < 2)
            return BLOCK_W'($urandom);
        if (r == 2 && span < MAX_BLOCKS)
            return BLOCK_W'($urandom_range(span, MAX_BLOCKS - 1));
        return BLOCK_W'($urandom_range(1, span - 1));
    endfunction

    initial
    begin : stimulus
        logic [VOL_W-1:0] phase_vol [10];
        int r;
        phase_vol = '{13'd0, 13'd3, 13'd5, 13'd9, 13'd17, 13'd40, 13'd4097, 13'd300,
                      13'd2, 13'd4096};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_word(ACT_ALLOC, 12'd0);
        push_word(ACT_UNUSED, 12'hFFF);
        push_word(ACT_RELEASE, 12'd0);
        push_word(ACT_RELEASE, 12'hFFF);
        push_word(ACT_ALLOC, 12'hABC);
        push_word(ACT_ALLOC, 12'h543);
        push_word(ACT_FORMAT, 12'h555);
        push_word(ACT_RELEASE, 12'd7);
        push_word(ACT_ALLOC, 12'd0);
        push_word(ACT_ALLOC, 12'd0);
        push_word(ACT_ALLOC, 12'd0);
        push_word(ACT_RELEASE, 12'd2);
        push_word(ACT_ALLOC, 12'd0);
        settle();
        load_volume(13'd2);
        push_word(ACT_FORMAT, 12'd0);
        push_word(ACT_ALLOC, 12'd0);
        push_word(ACT_ALLOC, 12'd0);
        push_word(ACT_RELEASE, 12'd1);
        push_word(ACT_RELEASE, 12'd2);
        push_word(ACT_ALLOC, 12'd0);
        settle();
        load_volume(13'd1);
        push_word(ACT_FORMAT, 12'd0);
        push_word(ACT_RELEASE, 12'd1);
        push_word(ACT_ALLOC, 12'd0);
        settle();
        load_volume(13'h1FFF);
        push_word(ACT_FORMAT, 12'd0);
        push_word(ACT_RELEASE, 12'hFFF);
        push_word(ACT_ALLOC, 12'd0);

        foreach (phase_vol[p])
        begin
            settle();
            load_volume(phase_vol[p]);
            push_word(ACT_FORMAT, BLOCK_W'($urandom));
            repeat (40)
            begin
                r = $urandom_range(0, 99);
                if (r < 46)
                    push_word(ACT_ALLOC, BLOCK_W'($urandom));
                else if (r < 86)
                    push_word(ACT_RELEASE, pick_release(vol_now));
                else if (r < 94)
                    push_word(ACT_FORMAT, BLOCK_W'($urandom));
                else
                    push_word(ACT_UNUSED, BLOCK_W'($urandom));
            end
        end
        settle();

        $display("Sent %0d words under %0d volume settings: %0d allocates, %0d releases,",
                 n_alloc + n_release + n_format + n_unused, settings_used, n_alloc, n_release);
        $display("%0d formats and %0d unused action codes; %0d mismatches found.",
                 n_format, n_unused, mismatch_count);
        if (mismatch_count == 0 && results_owed == 0)
            $display("PASS free_extent_block_allocator");
        else
            $display("FAIL free_extent_block_allocator");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/feba_pkg.sv
rtl/feba_ram.sv
rtl/free_extent_block_allocator.sv
rtl/feba_checker.sv
verif/feba_reply_checker.sv
verif/tb.sv
